@@ sv/auto_ranging_waveform_plotter_macros.svh @@
// Assertion macros used by the plotter's checked top level.
`ifndef AUTO_RANGING_WAVEFORM_PLOTTER_MACROS_SVH
`define AUTO_RANGING_WAVEFORM_PLOTTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARWP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARWP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/arwp_pkg.sv @@
// Shared constants, types and register codes of the auto-ranging waveform plotter.
package arwp_pkg;

  // Screen geometry and the margin added around each sweep's range.
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int RANGE_MARGIN  = 20;

  // Field widths.
  localparam int SAMPLE_W = 12;
  localparam int X_W      = 9;
  localparam int ROW_W    = 11;
  localparam int ROW_MAX  = 1023;
  localparam int COL_W    = $clog2(SCREEN_WIDTH + 1);

  // Display bounds span -20..4115, so they need two bits over a sample.
  localparam int BOUND_W  = SAMPLE_W + 2;
  localparam int SPAN_W   = BOUND_W;
  localparam int NUM_W    = BOUND_W + $clog2(SCREEN_HEIGHT + 1);
  localparam int CNT_W    = $clog2(NUM_W);

  localparam logic signed [NUM_W-1:0]   HEIGHT_S = NUM_W'(SCREEN_HEIGHT);
  localparam logic signed [BOUND_W-1:0] MARGIN_S = BOUND_W'(RANGE_MARGIN);

  // Stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * X_W + 2 * ROW_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } cfg_reg_t;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic                     draw;
    logic                     clear;
    logic [X_W-1:0]           x_end;
    logic signed [NUM_W-1:0]  num;
    logic signed [SPAN_W-1:0] span;
  } q_entry_t;

  // Restart request from a register write, with the new previous row.
  typedef struct packed {
    logic                    restart;
    logic signed [ROW_W-1:0] prev_row;
  } restart_t;

endpackage

@@ sv/arwp_queue.sv @@
// Two-entry queue that decouples the classifying front part from the divider.
module arwp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  arwp_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output arwp_pkg::q_entry_t head,
  output logic              not_empty
);
  import arwp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t            store [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [FILL_W-1:0]   fill;

  assign full      = (fill == FILL_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = store[rd_ptr];

  // Pointer and fill count bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && not_empty)) begin
        fill <= fill + 1'b1;
      end else if (!(push && !full) && (pop && not_empty)) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ sv/arwp_front.sv @@
// Front part: configuration registers, sweep tracking and item classification.
module arwp_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [arwp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arwp_pkg::SAMPLE_W-1:0]  cfg_data,
  input  logic                           accept,
  input  logic [arwp_pkg::SAMPLE_W-1:0]  sample,
  output arwp_pkg::q_entry_t             entry,
  output arwp_pkg::restart_t             rs
);
  import arwp_pkg::*;

  logic [SAMPLE_W-1:0]       range_low;
  logic [SAMPLE_W-1:0]       range_high;
  logic [COL_W-1:0]          column;
  logic [SAMPLE_W-1:0]       sweep_min;
  logic [SAMPLE_W-1:0]       sweep_max;
  logic signed [BOUND_W-1:0] display_low;
  logic signed [BOUND_W-1:0] display_high;

  logic [SAMPLE_W-1:0]       low_next;
  logic [SAMPLE_W-1:0]       high_next;
  logic [SAMPLE_W-1:0]       min_next;
  logic [SAMPLE_W-1:0]       max_next;
  logic signed [BOUND_W-1:0] sample_s;
  logic signed [BOUND_W-1:0] diff;
  logic                      wrap;

  // Register values that a write in this cycle leaves behind.
  always_comb begin
    low_next  = range_low;
    high_next = range_high;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RANGE_LOW:  low_next  = cfg_data;
        REG_RANGE_HIGH: high_next = cfg_data;
      endcase
    end
    rs.restart  = cfg_we;
    rs.prev_row = (low_next > SAMPLE_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : ROW_W'(low_next);
  end

  // Classify the incoming sample and build the work for the back part.
  always_comb begin
    sample_s = $signed(BOUND_W'(sample));
    min_next = (sample < sweep_min) ? sample : sweep_min;
    max_next = (sample > sweep_max) ? sample : sweep_max;
    wrap     = (column == COL_W'(SCREEN_WIDTH));
    diff     = display_high - sample_s;

    entry.draw  = (column != '0);
    entry.clear = wrap;
    entry.x_end = X_W'(column);
    entry.num   = NUM_W'(diff) * HEIGHT_S;
    entry.span  = display_high - display_low;
  end

  // Sweep state; a register write restarts the sweep from the new bounds.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low    <= '0;
      range_high   <= '1;
      column       <= '0;
      sweep_min    <= '1;
      sweep_max    <= '0;
      display_low  <= '0;
      display_high <= $signed(BOUND_W'({SAMPLE_W{1'b1}}));
    end else if (cfg_we) begin
      range_low    <= low_next;
      range_high   <= high_next;
      column       <= '0;
      sweep_min    <= high_next;
      sweep_max    <= low_next;
      display_low  <= $signed(BOUND_W'(low_next));
      display_high <= $signed(BOUND_W'(high_next));
    end else if (accept) begin
      if (wrap) begin
        column       <= '0;
        display_low  <= $signed(BOUND_W'(min_next)) - MARGIN_S;
        display_high <= $signed(BOUND_W'(max_next)) + MARGIN_S;
        sweep_min    <= range_high;
        sweep_max    <= range_low;
      end else begin
        column    <= column + 1'b1;
        sweep_min <= min_next;
        sweep_max <= max_next;
      end
    end
  end

endmodule

@@ sv/arwp_back.sv @@
// Back part: serial row divider, saturation and the output register.
module arwp_back (
  input  logic                             clk,
  input  logic                             rst,
  input  arwp_pkg::q_entry_t               head,
  input  logic                             head_valid,
  output logic                             pop,
  input  arwp_pkg::restart_t               rs,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [arwp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic [arwp_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  output logic                             m_axis_tlast
);
  import arwp_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [SPAN_W-1:0]       rem;
  logic [NUM_W-1:0]        quo;
  logic [SPAN_W-1:0]       dvs;
  logic                    neg;
  logic [X_W-1:0]          x_hold;
  logic                    clear_hold;
  logic signed [ROW_W-1:0] prev_row;

  logic [X_W-1:0]          x_start_r;
  logic [X_W-1:0]          x_end_r;
  logic signed [ROW_W-1:0] y_start_r;
  logic signed [ROW_W-1:0] y_end_r;
  logic                    draw_r;
  logic                    err_r;
  logic                    clear_r;

  logic                    slot_free;
  logic [NUM_W-1:0]        num_mag;
  logic [SPAN_W-1:0]       span_mag;
  logic [SPAN_W:0]         shifted;
  logic [SPAN_W:0]         trial;
  logic [SPAN_W-1:0]       rem_next;
  logic [NUM_W-1:0]        quo_next;
  logic                    last;
  logic signed [ROW_W-1:0] row_calc;

  assign m_axis_tdata = OUT_DATA_W'({y_end_r, x_end_r, y_start_r, x_start_r});
  assign m_axis_tuser = {err_r, draw_r};
  assign m_axis_tlast = clear_r;

  // Handshake with the queue and the magnitudes of the new operands.
  always_comb begin
    slot_free = !m_axis_tvalid || m_axis_tready;
    pop       = (state == ST_IDLE) && head_valid && slot_free;
    num_mag   = head.num[NUM_W-1] ? NUM_W'(-head.num) : NUM_W'(head.num);
    span_mag  = head.span[SPAN_W-1] ? SPAN_W'(-head.span) : SPAN_W'(head.span);
  end

  // One restoring division step per cycle, then sign and saturation.
  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    trial    = shifted - {1'b0, dvs};
    rem_next = trial[SPAN_W] ? shifted[SPAN_W-1:0] : trial[SPAN_W-1:0];
    quo_next = {quo[NUM_W-2:0], ~trial[SPAN_W]};
    last     = (count == CNT_W'(NUM_W - 1));
    if (neg) begin
      row_calc = (quo_next > NUM_W'(ROW_MAX + 1)) ? -ROW_W'(ROW_MAX + 1)
                                                  : -ROW_W'(quo_next);
    end else begin
      row_calc = (quo_next > NUM_W'(ROW_MAX)) ? ROW_W'(ROW_MAX) : ROW_W'(quo_next);
    end
  end

  // Sequencer, divider registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      prev_row      <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (rs.restart) begin
        prev_row <= rs.prev_row;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (!head.draw) begin
              // First column of a sweep: nothing drawn.
              m_axis_tvalid <= 1'b1;
              draw_r        <= 1'b0;
              err_r         <= 1'b0;
              clear_r       <= head.clear;
              x_start_r     <= '0;
              x_end_r       <= '0;
              y_start_r     <= '0;
              y_end_r       <= '0;
            end else if (head.span == '0) begin
              // Empty display range: row forced to zero and flagged.
              m_axis_tvalid <= 1'b1;
              draw_r        <= 1'b1;
              err_r         <= 1'b1;
              clear_r       <= head.clear;
              x_start_r     <= head.x_end - 1'b1;
              x_end_r       <= head.x_end;
              y_start_r     <= prev_row;
              y_end_r       <= '0;
              prev_row      <= '0;
            end else begin
              rem        <= '0;
              quo        <= num_mag;
              dvs        <= span_mag;
              neg        <= head.num[NUM_W-1] ^ head.span[SPAN_W-1];
              x_hold     <= head.x_end;
              clear_hold <= head.clear;
              count      <= '0;
              state      <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem   <= rem_next;
          quo   <= quo_next;
          count <= count + 1'b1;
          if (last) begin
            m_axis_tvalid <= 1'b1;
            draw_r        <= 1'b1;
            err_r         <= 1'b0;
            clear_r       <= clear_hold;
            x_start_r     <= x_hold - 1'b1;
            x_end_r       <= x_hold;
            y_start_r     <= prev_row;
            y_end_r       <= row_calc;
            prev_row      <= row_calc;
            state         <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/auto_ranging_waveform_plotter.sv @@
// Top level of the auto-ranging waveform plotter.
// Each accepted sample yields one result item: a line segment from the previous
// point to the new column, scaled into 240 rows by the range that the previous
// sweep left (its minimum and maximum widened by 20), with a screen clear on the
// last segment of a 320-column sweep. The front part takes a sample
// whenever its two-entry queue has room. The back part sets the rate:
// a segment that needs scaling is loaded into the serial divider, which
// retires one quotient bit per cycle, while the first column of a sweep
// and an empty display range are answered directly. A register write restarts
// the sweep at once and should only be issued while the block is idle.
`include "auto_ranging_waveform_plotter_macros.svh"

module auto_ranging_waveform_plotter (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [arwp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arwp_pkg::SAMPLE_W-1:0]    cfg_data,
  // Sample stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [arwp_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // sample
  // Segment stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [arwp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // x_start, y_start, x_end, y_end
  output logic [arwp_pkg::OUT_USER_W-1:0]  m_axis_tuser,  // draw_valid, range_error
  output logic                             m_axis_tlast   // clear_screen
);
  import arwp_pkg::*;

  logic     accept;
  logic     q_full;
  logic     q_pop;
  logic     q_not_empty;
  q_entry_t entry;
  q_entry_t head;
  restart_t rs;

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Front part: register file and sweep tracking.
  arwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .sample    (s_axis_tdata[SAMPLE_W-1:0]),
    .entry     (entry),
    .rs        (rs)
  );

  // Queue between the two parts.
  arwp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (head),
    .not_empty  (q_not_empty)
  );

  // Back part: row divider and output register.
  arwp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (q_not_empty),
    .pop           (q_pop),
    .rs            (rs),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A sweep always ends on the last column of the screen.
  `ARWP_ASSERT_SAME(a_clear_on_last_column, m_axis_tvalid && m_axis_tlast && m_axis_tuser[0], m_axis_tdata[2*X_W+ROW_W-1:X_W+ROW_W] == X_W'(SCREEN_WIDTH), "clear_screen away from the last column")
  // An empty display range forces the new row to zero.
  `ARWP_ASSERT_SAME(a_error_row_zero, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0] && (m_axis_tdata[2*X_W+2*ROW_W-1:2*X_W+ROW_W] == '0), "range_error with a non-zero row")
  // A result without a segment carries no coordinates.
  `ARWP_ASSERT_SAME(a_no_draw_zero, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata == '0) && !m_axis_tuser[1], "coordinates on an undrawn result")
  // The first column of a sweep is answered in the very next cycle.
  `ARWP_ASSERT_NEXT(a_first_column_fast, q_pop && !head.draw, m_axis_tvalid && !m_axis_tuser[0], "first column result not presented")

endmodule
